// ===== rtl/rkq_pkg.sv =====
// ----------------------------------------------------------------------------
// rkq_pkg
// shared types, constants and key helpers of the record quicksort core
// ----------------------------------------------------------------------------
package rkq_pkg;

  localparam int DEFAULT_DEPTH = 64;
  localparam int ID_W    = 12;
  localparam int PRICE_W = 31;
  localparam int CNT8_W  = 8;
  localparam int REC_W   = ID_W + PRICE_W + 3 * CNT8_W;
  localparam int KEY_W   = PRICE_W;

  // key column codes
  localparam logic [1:0] COL_PRICE   = 2'd0;
  localparam logic [1:0] COL_ROOMS   = 2'd1;
  localparam logic [1:0] COL_BATHS   = 2'd2;
  localparam logic [1:0] COL_PARKING = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_SORT_COLUMN = 2'd0;
  localparam logic [1:0] REG_DESCENDING  = 2'd1;

  // packed record: id | price | parking | baths | rooms
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] price;
    logic [CNT8_W-1:0]  parking;
    logic [CNT8_W-1:0]  baths;
    logic [CNT8_W-1:0]  rooms;
  } rec_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PUSH_INIT, S_POP, S_POP_WAIT, S_PIV_RD, S_PIV_WAIT,
    S_SCAN_RD, S_SCAN_CMP, S_SWAP_A, S_SWAP_B, S_FIN_RD, S_FIN_A,
    S_FIN_B, S_PUSH_R, S_PUSH_L, S_EMIT, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic push_init;
    logic pop;
    logic pop_latch;
    logic piv_rd;
    logic piv_latch;
    logic scan_rd;
    logic scan_latch;
    logic advance;
    logic place_inc;
    logic swap_rd;
    logic wr_place_scan;
    logic wr_scan_rdata;
    logic fin_rd;
    logic wr_place_pivot;
    logic wr_hi_rdata;
    logic push_r;
    logic push_l;
    logic emit_rd;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic need_sort;
    logic top_zero;
    logic range_empty;
    logic scan_at_hi;
    logic goes_first;
    logic place_eq_scan;
    logic emit_last;
  } stat_t;

  function automatic logic [KEY_W-1:0] key_of(rec_t r, logic [1:0] col);
    logic [KEY_W-1:0] k;
    k = '0;
    case (col)
      COL_PRICE:   k = r.price;
      COL_ROOMS:   k = {{(KEY_W-CNT8_W){1'b0}}, r.rooms};
      COL_BATHS:   k = {{(KEY_W-CNT8_W){1'b0}}, r.baths};
      default:     k = {{(KEY_W-CNT8_W){1'b0}}, r.parking};
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/rkq_ram.sv =====
// ----------------------------------------------------------------------------
// rkq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rkq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rkq_dp.sv =====
// ----------------------------------------------------------------------------
// rkq_dp
// record store, range stack, partition pointers and key compare
// ----------------------------------------------------------------------------
module rkq_dp
  import rkq_pkg::*;
#(
  parameter int RECORD_DEPTH = DEFAULT_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              st,
  input  logic [1:0]         sort_col,
  input  logic               sort_desc,
  input  rec_t               in_rec,
  output rec_t               out_rec,
  output logic               out_valid,
  output logic               out_last,
  output logic               out_ovf
);

  localparam int IW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
  localparam int CW = $clog2(RECORD_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(RECORD_DEPTH);

  logic [CW-1:0] count_r, top_r;
  logic          ovf_r, valid_r, last_r;
  logic [IW-1:0] lo_r, hi_r, scan_r, place_r, emit_r;
  rec_t          pivot_r, scan_rec_r;

  logic          rec_we, rec_re;
  logic [IW-1:0] rec_waddr, rec_raddr;
  rec_t          rec_wdata, rec_rdata;
  logic          stk_we;
  logic [IW-1:0] stk_waddr, stk_raddr;
  logic [2*IW-1:0] stk_wdata, stk_rdata;

  logic [IW-1:0]   hi_init;
  logic [IW:0]     place_p1, lo_p1;
  logic            push_r_ok, push_l_ok, full;
  logic [KEY_W-1:0] k_a, k_b;

  rkq_ram #(.WIDTH(REC_W), .DEPTH(RECORD_DEPTH)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .re(rec_re), .raddr(rec_raddr), .rdata(rec_rdata)
  );

  rkq_ram #(.WIDTH(2*IW), .DEPTH(RECORD_DEPTH)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(cmd.pop), .raddr(stk_raddr), .rdata(stk_rdata)
  );

  assign full      = (count_r == DEPTH_C);
  assign hi_init   = IW'(count_r - CW'(1));
  assign place_p1  = {1'b0, place_r} + (IW+1)'(1);
  assign lo_p1     = {1'b0, lo_r} + (IW+1)'(1);
  assign push_r_ok = (place_p1 < {1'b0, hi_r}) && (top_r < DEPTH_C);
  assign push_l_ok = ({1'b0, place_r} > lo_p1) && (top_r < DEPTH_C);

  // record store ports
  always_comb begin
    rec_re    = cmd.piv_rd | cmd.scan_rd | cmd.swap_rd | cmd.fin_rd | cmd.emit_rd;
    rec_raddr = emit_r;
    if (cmd.piv_rd) begin
      rec_raddr = hi_r;
    end else if (cmd.scan_rd) begin
      rec_raddr = scan_r;
    end else if (cmd.swap_rd || cmd.fin_rd) begin
      rec_raddr = place_r;
    end
    rec_we    = (cmd.load & ~full) | cmd.wr_place_scan | cmd.wr_scan_rdata
              | cmd.wr_place_pivot | cmd.wr_hi_rdata;
    rec_waddr = count_r[IW-1:0];
    rec_wdata = in_rec;
    if (cmd.wr_place_scan) begin
      rec_waddr = place_r;
      rec_wdata = scan_rec_r;
    end else if (cmd.wr_scan_rdata) begin
      rec_waddr = scan_r;
      rec_wdata = rec_rdata;
    end else if (cmd.wr_place_pivot) begin
      rec_waddr = place_r;
      rec_wdata = pivot_r;
    end else if (cmd.wr_hi_rdata) begin
      rec_waddr = hi_r;
      rec_wdata = rec_rdata;
    end
  end

  // range stack ports, entries are {hi, lo}
  always_comb begin
    stk_we    = cmd.push_init | (cmd.push_r & push_r_ok) | (cmd.push_l & push_l_ok);
    stk_waddr = top_r[IW-1:0];
    stk_raddr = IW'(top_r - CW'(1));
    stk_wdata = {hi_init, {IW{1'b0}}};
    if (cmd.push_r) begin
      stk_wdata = {hi_r, place_p1[IW-1:0]};
    end else if (cmd.push_l) begin
      stk_wdata = {IW'(place_r - IW'(1)), lo_r};
    end
  end

  // key compare of freshly read record against the pivot
  assign k_a = key_of(rec_rdata, sort_col);
  assign k_b = key_of(pivot_r, sort_col);

  always_comb begin
    st.need_sort     = full | (count_r != '0);
    st.top_zero      = (top_r == '0);
    st.range_empty   = (stk_rdata[IW-1:0] >= stk_rdata[2*IW-1:IW]);
    st.scan_at_hi    = (scan_r == hi_r);
    st.goes_first    = sort_desc ? (k_a > k_b) : (k_a < k_b);
    st.place_eq_scan = (place_r == scan_r);
    st.emit_last     = ({1'b0, emit_r} == (IW+1)'(hi_init)) ||
                       (CW'(emit_r) == CW'(count_r - CW'(1)));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      top_r   <= '0;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      valid_r <= cmd.emit_rd;
      last_r  <= cmd.emit_rd & st.emit_last;
      if (cmd.load) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + CW'(1);
        end
      end
      if (cmd.done) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end
      if (cmd.push_init) begin
        top_r <= CW'(1);
      end else if (cmd.pop) begin
        top_r <= top_r - CW'(1);
      end else if (stk_we) begin
        top_r <= top_r + CW'(1);
      end
    end
  end

  // pointers and held records
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      emit_r <= '0;
    end else if (cmd.emit_rd) begin
      emit_r <= emit_r + IW'(1);
    end
    if (cmd.pop_latch) begin
      lo_r <= stk_rdata[IW-1:0];
      hi_r <= stk_rdata[2*IW-1:IW];
    end
    if (cmd.piv_rd) begin
      scan_r  <= lo_r;
      place_r <= lo_r;
    end else begin
      if (cmd.advance) begin
        scan_r <= scan_r + IW'(1);
      end
      if (cmd.place_inc) begin
        place_r <= place_r + IW'(1);
      end
    end
    if (cmd.piv_latch) begin
      pivot_r <= rec_rdata;
    end
    if (cmd.scan_latch) begin
      scan_rec_r <= rec_rdata;
    end
  end

  assign out_rec   = rec_rdata;
  assign out_valid = valid_r;
  assign out_last  = last_r;
  assign out_ovf   = ovf_r;

`ifndef SYNTH
  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= DEPTH_C) else $error("range stack overrun");
  a_place_le_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_rd |-> place_r <= scan_r) else $error("place passed scan");
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> $past(cmd.emit_rd)) else $error("strobe without emit read");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C) else $error("fill count overrun");
`endif

endmodule

// ===== rtl/rkq_ctrl.sv =====
// ----------------------------------------------------------------------------
// rkq_ctrl
// sequencer for load, stack driven partition passes and emission
// ----------------------------------------------------------------------------
module rkq_ctrl
  import rkq_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  in_last,
  input  stat_t st,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = start & (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_last) begin
          state_nxt = st.need_sort ? S_PUSH_INIT : S_EMIT;
        end
      end
      S_PUSH_INIT: state_nxt = S_POP;
      S_POP:       state_nxt = st.top_zero ? S_EMIT : S_POP_WAIT;
      S_POP_WAIT:  state_nxt = st.range_empty ? S_POP : S_PIV_RD;
      S_PIV_RD:    state_nxt = S_PIV_WAIT;
      S_PIV_WAIT:  state_nxt = S_SCAN_RD;
      S_SCAN_RD:   state_nxt = st.scan_at_hi ? S_FIN_RD : S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (st.goes_first && !st.place_eq_scan) begin
          state_nxt = S_SWAP_A;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SWAP_A:    state_nxt = S_SWAP_B;
      S_SWAP_B:    state_nxt = S_SCAN_RD;
      S_FIN_RD:    state_nxt = S_FIN_A;
      S_FIN_A:     state_nxt = S_FIN_B;
      S_FIN_B:     state_nxt = S_PUSH_R;
      S_PUSH_R:    state_nxt = S_PUSH_L;
      S_PUSH_L:    state_nxt = S_POP;
      S_EMIT:      state_nxt = st.emit_last ? S_DONE : S_EMIT;
      S_DONE:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:      cmd.load = accept;
      S_PUSH_INIT: cmd.push_init = 1'b1;
      S_POP:       cmd.pop = ~st.top_zero;
      S_POP_WAIT:  cmd.pop_latch = 1'b1;
      S_PIV_RD:    cmd.piv_rd = 1'b1;
      S_PIV_WAIT:  cmd.piv_latch = 1'b1;
      S_SCAN_RD:   cmd.scan_rd = ~st.scan_at_hi;
      S_SCAN_CMP: begin
        cmd.scan_latch = 1'b1;
        if (st.goes_first && !st.place_eq_scan) begin
          cmd.swap_rd = 1'b1;
        end else begin
          cmd.advance   = 1'b1;
          cmd.place_inc = st.goes_first;
        end
      end
      S_SWAP_A:    cmd.wr_place_scan = 1'b1;
      S_SWAP_B: begin
        cmd.wr_scan_rdata = 1'b1;
        cmd.advance       = 1'b1;
        cmd.place_inc     = 1'b1;
      end
      S_FIN_RD:    cmd.fin_rd = 1'b1;
      S_FIN_A:     cmd.wr_place_pivot = 1'b1;
      S_FIN_B:     cmd.wr_hi_rdata = 1'b1;
      S_PUSH_R:    cmd.push_r = 1'b1;
      S_PUSH_L:    cmd.push_l = 1'b1;
      S_EMIT:      cmd.emit_rd = 1'b1;
      S_DONE:      cmd.done = 1'b1;
      default:     cmd = '0;
    endcase
  end

`ifndef SYNTH
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy) else $error("load outside idle");
  a_done_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |-> $past(state_r == S_EMIT)) else $error("done without emit");
  a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_place_scan |=> cmd.wr_scan_rdata) else $error("swap half done");
`endif

endmodule

// ===== rtl/record_key_quicksort_core.sv =====
// ----------------------------------------------------------------------------
// record_key_quicksort_core
// loads records, sorts them on a chosen key by lomuto quicksort, emits them
// ----------------------------------------------------------------------------
// loading takes one request per cycle while busy is low; a request without
// the last mark returns nothing. after the last request the core sorts with
// one record ram port: each partition pops a range, latches the pivot, reads
// and compares each scanned record, writes both halves of any exchange,
// places the pivot and pushes ranges; empty ranges are only popped. then n
// results leave one per cycle; the receiver cannot stall. synchronous
// active-low reset empties the set and clears configuration, not the store.
module record_key_quicksort_core
  import rkq_pkg::*;
#(
  parameter int RECORD_DEPTH = DEFAULT_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic [ID_W-1:0]    in_record_id,
  input  logic [PRICE_W-1:0] in_price_value,
  input  logic [7:0]         in_room_count,
  input  logic [7:0]         in_bath_count,
  input  logic [7:0]         in_parking_count,
  input  logic               in_last_record,
  // results
  output logic               out_valid,
  output logic [ID_W-1:0]    out_id,
  output logic [PRICE_W-1:0] out_price,
  output logic [7:0]         out_rooms,
  output logic [7:0]         out_baths,
  output logic [7:0]         out_parking,
  output logic               out_last,
  output logic               out_overflowed,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [1:0]         cfg_data
);

  cmd_t       cmd;
  stat_t      st;
  rec_t       in_rec, out_rec;
  logic [1:0] sort_col_r;
  logic       sort_desc_r;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_col_r  <= COL_PRICE;
      sort_desc_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SORT_COLUMN: sort_col_r  <= cfg_data;
        REG_DESCENDING:  sort_desc_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pack the incoming record
  always_comb begin
    in_rec.id      = in_record_id;
    in_rec.price   = in_price_value;
    in_rec.rooms   = in_room_count;
    in_rec.baths   = in_bath_count;
    in_rec.parking = in_parking_count;
  end

  rkq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_last(in_last_record),
    .st(st), .cmd(cmd), .busy(busy)
  );

  rkq_dp #(.RECORD_DEPTH(RECORD_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .sort_col(sort_col_r), .sort_desc(sort_desc_r),
    .in_rec(in_rec),
    .out_rec(out_rec), .out_valid(out_valid), .out_last(out_last),
    .out_ovf(out_overflowed)
  );

  // result fields straight off the registered ram read
  assign out_id      = out_rec.id;
  assign out_price   = out_rec.price;
  assign out_rooms   = out_rec.rooms;
  assign out_baths   = out_rec.baths;
  assign out_parking = out_rec.parking;

endmodule
